// ----- design/debounced_preset_panel_assert.svh -----
// assertion macros used by the checker file
`ifndef DEBOUNCED_PRESET_PANEL_ASSERT_SVH
`define DEBOUNCED_PRESET_PANEL_ASSERT_SVH

// same-cycle implication, off while reset is held
`define DPP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpp assertion failed");

// next-cycle implication, off while reset is held
`define DPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpp assertion failed");

// next-cycle implication that also holds through reset
`define DPP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dpp assertion failed");

`endif

// ----- design/dpp_pkg.sv -----
// types and constants for the debounced preset panel
`default_nettype none
package dpp_pkg;

    localparam int unsigned NumButtons = 3;

    localparam logic [3:0]  DebounceReset = 4'd3;
    localparam logic [3:0]  CountMax      = 4'd15;

    localparam logic [22:0] ThrLow    = 23'd4194304;
    localparam logic [22:0] ThrHigh   = 23'd1677721;
    localparam logic [3:0]  GainLow   = 4'd4;
    localparam logic [3:0]  GainHigh  = 4'd12;
    localparam logic [18:0] RateSlow  = 19'd89478;
    localparam logic [18:0] RateFast  = 19'd357914;
    localparam logic [6:0]  DepthSlow = 7'd80;
    localparam logic [6:0]  DepthFast = 7'd100;
    localparam logic [5:0]  LedSw0    = 6'h02;
    localparam logic [5:0]  LedSw1    = 6'h10;

    localparam int unsigned BtnDist   = 0;
    localparam int unsigned BtnWobble = 1;
    localparam int unsigned BtnWah    = 2;

    typedef enum logic [1:0] {
        WAH_FLOOR6 = 2'd0,
        WAH_FLOOR4 = 2'd1,
        WAH_FLOOR0 = 2'd2
    } wah_step_t;

    typedef struct packed {
        logic [1:0] switches;
        logic [2:0] buttons;
    } dpp_in_t;

    typedef struct packed {
        logic        distortion_enable;
        logic        wobble_enable;
        logic        enables_changed;
        logic [22:0] drive_threshold;
        logic [3:0]  drive_gain;
        logic [18:0] wobble_rate;
        logic [6:0]  wobble_depth;
        logic [2:0]  wah_floor;
        logic [1:0]  preset_leds;
        logic [5:0]  rgb_leds;
    } dpp_out_t;

    // each button's debounce verdict for this tick
    typedef struct packed {
        logic [NumButtons-1:0] fire;
    } dpp_fire_t;

    function automatic logic [2:0] floor_of(input logic [1:0] step);
        logic [2:0] result;
        case (step)
            WAH_FLOOR6: result = 3'd6;
            WAH_FLOOR4: result = 3'd4;
            default:    result = 3'd0;
        endcase
        return result;
    endfunction

endpackage
`default_nettype wire

// ----- design/debounced_preset_panel.sv -----
// Debounced preset panel: switch and button poll ticks in, panel settings out.
// s_ channel: one request per poll tick carrying the 2 switch bits and 3 button
//   bits; m_ channel: one result per request with the enables, the distortion
//   and wobble presets, the wah floor and the LED patterns after that tick.
// cfg channel: writes the debounce length (pressed ticks before a press acts);
//   always ready, write it only while no request is in flight.
// Path: an accepted request passes the input register, then the result
//   register, before m_valid rises.
// Throughput: one request per cycle while m_ready is high; set by the single
//   update step between the input register and the result register.
// Reset (aresetn low, synchronous): both registers empty, presets back to low
//   distortion, slow wobble, wah floor 6, debounce length 3; the first tick
//   after reset reports the enables as changed.
// Stall: while m_ready is low the result is held; one more request waits in
//   the input register, after which s_ready drops until the result is taken.
`default_nettype none
module debounced_preset_panel (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dpp_pkg::dpp_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dpp_pkg::dpp_out_t      m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [3:0]        cfg_data
);

    logic              in_valid_reg;
    dpp_pkg::dpp_in_t  in_data_reg;
    logic              out_valid_reg;
    dpp_pkg::dpp_out_t out_data_reg;
    logic [3:0]        presses_reg;
    logic              advance;
    dpp_pkg::dpp_fire_t fires;
    dpp_pkg::dpp_out_t result;

    // request moves on once the result register is free or being emptied
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presses_reg <= dpp_pkg::DebounceReset;
        end else if (cfg_valid) begin
            presses_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    for (genvar i = 0; i < dpp_pkg::NumButtons; i++) begin : g_btn
        dpp_debounce u_debounce (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .pressed (in_data_reg.buttons[i]),
            .presses (presses_reg),
            .fire    (fires.fire[i])
        );
    end

    dpp_settings u_settings (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .switches (in_data_reg.switches),
        .fires    (fires),
        .result   (result)
    );

endmodule
`default_nettype wire

// ----- design/dpp_debounce.sv -----
// press counter and fired latch for one button
`default_nettype none
module dpp_debounce (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic       pressed,
    input  wire logic [3:0] presses,
    output logic            fire
);

    logic [3:0] count_reg, count_next;
    logic       fired_reg, fired_next;
    logic [3:0] count_inc;

    always_comb begin
        count_inc  = (count_reg < dpp_pkg::CountMax) ? count_reg + 4'd1 : count_reg;
        fire       = 1'b0;
        count_next = count_reg;
        fired_next = fired_reg;
        if (!pressed) begin
            count_next = 4'd0;
            fired_next = 1'b0;
        end else if (!fired_reg) begin
            count_next = count_inc;
            // a setting of zero passes on the first pressed tick, same as one
            if (count_inc >= presses) begin
                fire       = 1'b1;
                fired_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
            fired_reg <= 1'b0;
        end else if (advance) begin
            count_reg <= count_next;
            fired_reg <= fired_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/dpp_settings.sv -----
// preset state and result assembly
`default_nettype none
module dpp_settings (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [1:0]        switches,
    input  wire dpp_pkg::dpp_fire_t fires,
    output dpp_pkg::dpp_out_t      result
);

    logic       dist_high_reg, dist_high_next;
    logic       wobble_fast_reg, wobble_fast_next;
    logic [1:0] wah_step_reg, wah_step_next;
    logic [1:0] last_sw_reg;
    logic       last_valid_reg;

    always_comb begin
        dist_high_next   = dist_high_reg ^ fires.fire[dpp_pkg::BtnDist];
        wobble_fast_next = wobble_fast_reg ^ fires.fire[dpp_pkg::BtnWobble];
        wah_step_next    = wah_step_reg;
        if (fires.fire[dpp_pkg::BtnWah]) begin
            wah_step_next = (wah_step_reg >= 2'(dpp_pkg::WAH_FLOOR0)) ?
                            2'(dpp_pkg::WAH_FLOOR6) : wah_step_reg + 2'd1;
        end

        result.distortion_enable = switches[0];
        result.wobble_enable     = switches[1];
        result.enables_changed   = !last_valid_reg || (switches != last_sw_reg);
        result.drive_threshold   = dist_high_next ? dpp_pkg::ThrHigh : dpp_pkg::ThrLow;
        result.drive_gain        = dist_high_next ? dpp_pkg::GainHigh : dpp_pkg::GainLow;
        result.wobble_rate       = wobble_fast_next ? dpp_pkg::RateFast : dpp_pkg::RateSlow;
        result.wobble_depth      = wobble_fast_next ? dpp_pkg::DepthFast : dpp_pkg::DepthSlow;
        result.wah_floor         = dpp_pkg::floor_of(wah_step_next);
        result.preset_leds       = {wobble_fast_next, dist_high_next};
        result.rgb_leds          = (switches[0] ? dpp_pkg::LedSw0 : 6'd0) |
                                   (switches[1] ? dpp_pkg::LedSw1 : 6'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_high_reg   <= 1'b0;
            wobble_fast_reg <= 1'b0;
            wah_step_reg    <= 2'(dpp_pkg::WAH_FLOOR6);
            last_sw_reg     <= 2'd0;
            last_valid_reg  <= 1'b0;
        end else if (advance) begin
            dist_high_reg   <= dist_high_next;
            wobble_fast_reg <= wobble_fast_next;
            wah_step_reg    <= wah_step_next;
            last_sw_reg     <= switches;
            last_valid_reg  <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- design/dpp_checker.sv -----
// port-level checks for the debounced preset panel, bound to the top level
`default_nettype none
`include "debounced_preset_panel_assert.svh"
module dpp_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire dpp_pkg::dpp_in_t  s_data,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire dpp_pkg::dpp_out_t m_data,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [3:0]        cfg_data
);

    logic dist_high;
    logic [5:0] rgb_expect;

    assign dist_high  = m_data.preset_leds[0];
    assign rgb_expect = (m_data.distortion_enable ? dpp_pkg::LedSw0 : 6'd0) |
                        (m_data.wobble_enable ? dpp_pkg::LedSw1 : 6'd0);

    // held result stays put until taken
    `DPP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // no result can appear in the cycle right after reset
    `DPP_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)
    // distortion fields track the preset led
    `DPP_ASSERT_IMPL(a_dist_preset, aclk, aresetn, m_valid,
        (m_data.drive_gain == (dist_high ? dpp_pkg::GainHigh : dpp_pkg::GainLow)) &&
        (m_data.drive_threshold == (dist_high ? dpp_pkg::ThrHigh : dpp_pkg::ThrLow)))
    // rgb pattern follows the enables
    `DPP_ASSERT_IMPL(a_rgb, aclk, aresetn, m_valid, m_data.rgb_leds == rgb_expect)

    logic unused_ok;
    assign unused_ok = ^{s_valid, s_ready, s_data, cfg_valid, cfg_ready, cfg_data};

endmodule

bind debounced_preset_panel dpp_checker u_dpp_checker (.*);
`default_nettype wire

// ----- test/testbench.sv -----
// testbench for the debounced preset panel: random poll ticks against a cycle-free predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int PhaseTicks    = 250;
    localparam int NumPhases     = 6;
    localparam int HoldOffCycles = 300;
    localparam int HoldOffAfter  = 600;
    localparam int CycleLimit    = 600000;

    class panel_scoreboard;
        logic [3:0]         press_len;
        logic [1:0]         prev_switches;
        bit                 prev_seen;
        logic [3:0]         held_ticks [dpp_pkg::NumButtons];
        bit                 latched [dpp_pkg::NumButtons];
        bit                 dist_high;
        bit                 wobble_fast;
        dpp_pkg::wah_step_t wah_pos;
        dpp_pkg::dpp_out_t  panel_expected [$];
        int                 errors;

        function new();
            press_len = dpp_pkg::DebounceReset;
            prev_switches = '0;
            prev_seen = 0;
            for (int b = 0; b < dpp_pkg::NumButtons; b++) begin
                held_ticks[b] = '0;
                latched[b] = 0;
            end
            dist_high = 0;
            wobble_fast = 0;
            wah_pos = dpp_pkg::WAH_FLOOR6;
            errors = 0;
        endfunction

        function void set_press_len(logic [3:0] value);
            press_len = value;
        endfunction

        // true on the tick that a held button acts; a zero length acts like one
        function bit press_acts(int b, bit pressed);
            if (!pressed) begin
                held_ticks[b] = '0;
                latched[b] = 0;
                return 0;
            end
            if (latched[b])
                return 0;
            if (held_ticks[b] != dpp_pkg::CountMax)
                held_ticks[b] = held_ticks[b] + 4'd1;
            if (held_ticks[b] >= press_len) begin
                latched[b] = 1;
                return 1;
            end
            return 0;
        endfunction

        function void note_tick(dpp_pkg::dpp_in_t req);
            dpp_pkg::dpp_out_t panel;
            panel = '0;
            panel.enables_changed = !prev_seen || (req.switches != prev_switches);
            prev_switches = req.switches;
            prev_seen = 1;
            if (press_acts(dpp_pkg::BtnDist, req.buttons[dpp_pkg::BtnDist]))
                dist_high = !dist_high;
            if (press_acts(dpp_pkg::BtnWobble, req.buttons[dpp_pkg::BtnWobble]))
                wobble_fast = !wobble_fast;
            if (press_acts(dpp_pkg::BtnWah, req.buttons[dpp_pkg::BtnWah]))
                wah_pos = (wah_pos == dpp_pkg::WAH_FLOOR0) ? dpp_pkg::WAH_FLOOR6 :
                          dpp_pkg::wah_step_t'(wah_pos + 2'd1);
            panel.distortion_enable = req.switches[0];
            panel.wobble_enable = req.switches[1];
            panel.drive_threshold = dist_high ? dpp_pkg::ThrHigh : dpp_pkg::ThrLow;
            panel.drive_gain = dist_high ? dpp_pkg::GainHigh : dpp_pkg::GainLow;
            panel.wobble_rate = wobble_fast ? dpp_pkg::RateFast : dpp_pkg::RateSlow;
            panel.wobble_depth = wobble_fast ? dpp_pkg::DepthFast : dpp_pkg::DepthSlow;
            case (wah_pos)
                dpp_pkg::WAH_FLOOR6: panel.wah_floor = 3'd6;
                dpp_pkg::WAH_FLOOR4: panel.wah_floor = 3'd4;
                default:             panel.wah_floor = 3'd0;
            endcase
            panel.preset_leds = {wobble_fast, dist_high};
            panel.rgb_leds = (req.switches[0] ? dpp_pkg::LedSw0 : 6'h00)
                           | (req.switches[1] ? dpp_pkg::LedSw1 : 6'h00);
            panel_expected.push_back(panel);
        endfunction

        function void compare_field(string name, logic [22:0] want, logic [22:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_panel(dpp_pkg::dpp_out_t got);
            dpp_pkg::dpp_out_t want;
            if (panel_expected.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = panel_expected.pop_front();
            compare_field("distortion_enable", 23'(want.distortion_enable),
                          23'(got.distortion_enable));
            compare_field("wobble_enable", 23'(want.wobble_enable), 23'(got.wobble_enable));
            compare_field("enables_changed", 23'(want.enables_changed),
                          23'(got.enables_changed));
            compare_field("drive_threshold", want.drive_threshold, got.drive_threshold);
            compare_field("drive_gain", 23'(want.drive_gain), 23'(got.drive_gain));
            compare_field("wobble_rate", 23'(want.wobble_rate), 23'(got.wobble_rate));
            compare_field("wobble_depth", 23'(want.wobble_depth), 23'(got.wobble_depth));
            compare_field("wah_floor", 23'(want.wah_floor), 23'(got.wah_floor));
            compare_field("preset_leds", 23'(want.preset_leds), 23'(got.preset_leds));
            compare_field("rgb_leds", 23'(want.rgb_leds), 23'(got.rgb_leds));
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    dpp_pkg::dpp_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    dpp_pkg::dpp_out_t m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [3:0]        cfg_data = '0;

    panel_scoreboard board;
    int cycles = 0;
    int results_taken = 0;
    bit quiet_run = 0;
    bit held_off = 0;

    debounced_preset_panel uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_tick(s_data);
            if (m_valid && m_ready) begin
                board.check_panel(m_data);
                results_taken++;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer(input dpp_pkg::dpp_in_t req);
        int gap;
        gap = quiet_run ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer_repeat(input logic [1:0] sw, input logic [2:0] btn, input int n);
        dpp_pkg::dpp_in_t req;
        req.switches = sw;
        req.buttons = btn;
        repeat (n) offer(req);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.panel_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_press_len(input logic [3:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.set_press_len(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_presses(input int count);
        dpp_pkg::dpp_in_t req;
        logic [1:0]       sw;
        logic [2:0]       mask;
        int               sent;
        int               span;
        int               hold;
        int               r;
        sent = 0;
        span = (board.press_len == 4'd0) ? 1 : int'(board.press_len);
        sw = 2'($urandom_range(0, 3));
        while (sent < count) begin
            quiet_run = ($urandom_range(0, 9) < 2);
            r = $urandom_range(0, 9);
            if (r < 2) begin
                // noise: anything goes on every tick
                repeat ($urandom_range(1, 8)) begin
                    req.switches = 2'($urandom_range(0, 3));
                    req.buttons = 3'($urandom_range(0, 7));
                    offer(req);
                    sent++;
                end
                sw = req.switches;
            end else begin
                if ($urandom_range(0, 1) == 0)
                    mask = 3'b001 << $urandom_range(0, 2);
                else
                    mask = 3'($urandom_range(1, 7));
                r = $urandom_range(0, 9);
                if (r < 7)
                    hold = $urandom_range(span, span + 3);
                else if (r < 9)
                    hold = $urandom_range(1, span);
                else
                    hold = $urandom_range(span + 5, span + 20);
                repeat (hold) begin
                    if ($urandom_range(0, 19) == 0)
                        sw = 2'($urandom_range(0, 3));
                    req.switches = sw;
                    req.buttons = mask;
                    // contact bounce may drop held buttons for one tick
                    if ($urandom_range(0, 24) == 0)
                        req.buttons = mask & 3'($urandom_range(0, 7));
                    offer(req);
                    sent++;
                end
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 9) == 0)
                        sw = 2'($urandom_range(0, 3));
                    req.switches = sw;
                    req.buttons = '0;
                    offer(req);
                    sent++;
                end
            end
        end
        quiet_run = 0;
    endtask

    initial begin : result_pacing
        int run_len;
        int gap_len;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held_off && results_taken >= HoldOffAfter) begin
                // long back-pressure so the block fills and stalls its input
                held_off = 1;
                m_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge aclk);
            end
            if ($urandom_range(0, 9) == 0)
                run_len = $urandom_range(100, 300);
            else
                run_len = $urandom_range(1, 20);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            gap_len = pick_gap();
            if (gap_len > 0) begin
                m_ready <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [3:0] fixed_lens [3];
        logic [3:0] len;
        fixed_lens = '{4'd15, 4'd0, 4'd1};
        board = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset length of 3: first tick change, switch walk, presses and wah wraparound
        offer_repeat(2'd0, 3'd0, 2);
        offer_repeat(2'd1, 3'd0, 1);
        offer_repeat(2'd2, 3'd0, 1);
        offer_repeat(2'd3, 3'd0, 1);
        offer_repeat(2'd3, 3'd1, 4);
        offer_repeat(2'd3, 3'd0, 1);
        offer_repeat(2'd1, 3'd6, 3);
        offer_repeat(2'd1, 3'd0, 1);
        offer_repeat(2'd2, 3'd4, 3);
        offer_repeat(2'd2, 3'd0, 1);
        offer_repeat(2'd0, 3'd7, 3);
        offer_repeat(2'd0, 3'd0, 1);

        for (int ph = 0; ph < NumPhases; ph++) begin
            len = (ph < 3) ? fixed_lens[ph] : 4'($urandom_range(0, 15));
            write_press_len(len);
            run_presses(PhaseTicks);
        end
        drain();
        repeat (8) @(posedge aclk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
